@@ hw/rtl/edbe_pkg.sv @@
// Package for the encoder detent and button event block.
// Holds event codes, register indexes, reset values and the shared adder width.
// No dependencies.
`default_nettype none

package edbe_pkg;

    // Event codes carried on the result channel
    typedef logic [1:0] t_event;
    localparam t_event EV_CW    = 2'd0;
    localparam t_event EV_CCW   = 2'd1;
    localparam t_event EV_CLICK = 2'd2;
    localparam t_event EV_LONG  = 2'd3;

    // Register indexes (byte address / 4)
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_STEPS    = 2'd0;
    localparam t_reg_idx REG_DEBOUNCE = 2'd1;
    localparam t_reg_idx REG_LONG     = 2'd2;
    localparam t_reg_idx REG_CLICK    = 2'd3;

    localparam logic [7:0]  RST_STEPS    = 8'd4;
    localparam logic [15:0] RST_DEBOUNCE = 16'd30;
    localparam logic [15:0] RST_LONG     = 16'd800;
    localparam logic [15:0] RST_CLICK    = 16'd500;

    localparam int DEF_MAX_DETENT_EVENTS = 15;
    localparam int DEF_TIME_WIDTH        = 32;

    // Shared adder: 32-bit signed operands plus one guard bit
    localparam int ALU_W = 33;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_alu_flags;

endpackage

`default_nettype wire

@@ hw/rtl/edbe_alu.sv @@
// Shared add/subtract unit of the encoder detent and button event block.
// Depends on edbe_pkg.
`default_nettype none

module edbe_alu
    import edbe_pkg::*;
(
    input  wire logic [ALU_W-1:0] i_a,
    input  wire logic [ALU_W-1:0] i_b,
    input  wire logic             i_sub,
    output logic      [ALU_W-1:0] o_y,
    output t_alu_flags            o_flags
);

    always_comb begin
        o_y           = i_sub ? (i_a - i_b) : (i_a + i_b);
        o_flags.neg   = o_y[ALU_W-1];
        o_flags.zero  = (o_y == '0);
    end

endmodule

`default_nettype wire

@@ hw/rtl/encoder_detent_and_button_events_top.sv @@
// Top level of the encoder detent and button event block: sequencer, state,
// registers and result register. Depends on edbe_pkg and edbe_alu.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  tick     | in        | i_valid / o_stall  | i_enc_position, i_button_level, i_now_ms
//  event    | out       | o_valid / i_stall  | o_event_code, o_last_of_run
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata, pready
//
// o_stall is high while the sequencer steps through DIFF, ACC, BT1, BT2 (only when
// the button level has settled), ROT (once more per detent event emitted, at most
// MAX_DETENT_EVENTS), BTN and FLUSH; all sums use the single shared 33-bit adder.
// A stalled result register holds the sequencer where it would push a beat.
// Reset is synchronous, active low; it restores the config registers and the state.
// o_stall drops at ST_IDLE, after any last beat of the tick enters the result register.
`default_nettype none

module encoder_detent_and_button_events_top
    import edbe_pkg::*;
#(
    parameter int MAX_DETENT_EVENTS = DEF_MAX_DETENT_EVENTS,
    parameter int TIME_WIDTH        = DEF_TIME_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_enc_position,
    input  wire logic        i_button_level,
    input  wire logic [31:0] i_now_ms,
    // event channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_code,
    output logic             o_last_of_run,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(MAX_DETENT_EVENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DETENT_EVENTS);
    localparam int TPAD = ALU_W - TIME_WIDTH;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_BT1   = 3'd3;
    localparam logic [2:0] ST_BT2   = 3'd4;
    localparam logic [2:0] ST_ROT   = 3'd5;
    localparam logic [2:0] ST_BTN   = 3'd6;
    localparam logic [2:0] ST_FLUSH = 3'd7;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  r_steps;
    logic [15:0] r_debounce;
    logic [15:0] r_long;
    logic [15:0] r_click;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps    <= RST_STEPS;
            r_debounce <= RST_DEBOUNCE;
            r_long     <= RST_LONG;
            r_click    <= RST_CLICK;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_STEPS:    r_steps    <= pwdata[7:0];
                REG_DEBOUNCE: r_debounce <= pwdata[15:0];
                REG_LONG:     r_long     <= pwdata[15:0];
                REG_CLICK:    r_click    <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_STEPS:    prdata = {24'd0, r_steps};
            REG_DEBOUNCE: prdata = {16'd0, r_debounce};
            REG_LONG:     prdata = {16'd0, r_long};
            REG_CLICK:    prdata = {16'd0, r_click};
            default:      prdata = '0;
        endcase
    end

    // A zero detent size behaves as one count per detent
    logic [7:0] w_step;
    assign w_step = (r_steps == 8'd0) ? 8'd1 : r_steps;

    // ------------------------------------------------------------------
    // Block state and latched tick
    // ------------------------------------------------------------------
    logic [2:0]            r_state, n_state;
    logic [31:0]           r_pos;
    logic                  r_pressed;
    logic [TIME_WIDTH-1:0] r_now;
    logic [31:0]           r_prev;
    logic [31:0]           r_diff;
    logic [31:0]           r_acc;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_pend;
    logic [TIME_WIDTH-1:0] r_ct;
    logic                  r_stable;
    logic [TIME_WIDTH-1:0] r_press;
    logic                  r_lf;
    logic                  r_aw;
    logic                  r_rose;
    logic                  r_btnv;
    t_event                r_btncode;
    // held beat: the newest event, sent once the next one (or none) is known
    logic                  r_hv;
    t_event                r_hcode;
    // result register
    logic                  r_ov;
    t_event                r_ocode;
    logic                  r_olast;

    // ------------------------------------------------------------------
    // Shared adder operand selection
    // ------------------------------------------------------------------
    logic [ALU_W-1:0]      w_a, w_b, w_y;
    logic                  w_sub;
    t_alu_flags            w_flags;
    logic [TIME_WIDTH-1:0] w_ct_eff;
    logic [TIME_WIDTH-1:0] w_dt;

    // A level change restarts the debounce window at this tick
    assign w_ct_eff = (r_pressed != r_pend) ? r_now : r_ct;
    assign w_dt     = w_y[TIME_WIDTH-1:0];

    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        unique case (r_state)
            ST_DIFF: begin
                w_a   = {1'b0, r_pos};
                w_b   = {1'b0, r_prev};
                w_sub = 1'b1;
            end
            ST_ACC: begin
                w_a = {r_acc[31], r_acc};
                w_b = {r_diff[31], r_diff};
            end
            ST_BT1: begin
                w_a   = {{TPAD{1'b0}}, r_now};
                w_b   = {{TPAD{1'b0}}, w_ct_eff};
                w_sub = 1'b1;
            end
            ST_BT2: begin
                w_a   = {{TPAD{1'b0}}, r_now};
                w_b   = {{TPAD{1'b0}}, r_press};
                w_sub = 1'b1;
            end
            ST_ROT: begin
                // move toward zero: subtract when positive, add when negative
                w_a   = {r_acc[31], r_acc};
                w_b   = {{(ALU_W-8){1'b0}}, w_step};
                w_sub = !r_acc[31];
            end
            default: ;
        endcase
    end

    edbe_alu u_alu (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sub   (w_sub),
        .o_y     (w_y),
        .o_flags (w_flags)
    );

    // ------------------------------------------------------------------
    // Decisions of the current step
    // ------------------------------------------------------------------
    logic       w_out_free;
    logic       w_accept;
    logic       w_hit;
    logic       w_settled;
    logic       w_long_hit;
    logic       w_click_hit;
    logic       w_push;
    t_event     w_pcode;
    logic       w_plast;
    logic       w_hold_wait;
    logic [31:0] w_sat;

    assign w_out_free = !r_ov || !i_stall;
    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != ST_IDLE);

    // Detent found: acc >= step when positive, acc <= -step when negative
    assign w_hit = (r_cnt < CNT_MAX) &&
                   (r_acc[31] ? (w_flags.neg || w_flags.zero) : !w_flags.neg);

    // Saturate the 33-bit accumulator sum to signed 32 bits
    always_comb begin
        if (w_y[32] != w_y[31]) begin
            w_sat = w_y[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_sat = w_y[31:0];
        end
    end

    assign w_settled   = (w_dt >= {{(TIME_WIDTH-16){1'b0}}, r_debounce});
    assign w_long_hit  = r_stable && !r_lf && !r_aw &&
                         (w_dt >= {{(TIME_WIDTH-16){1'b0}}, r_long});
    assign w_click_hit = r_rose && !r_lf &&
                         (w_dt >= {{(TIME_WIDTH-16){1'b0}}, r_debounce}) &&
                         (w_dt <  {{(TIME_WIDTH-16){1'b0}}, r_click});

    // A new event wants the held slot but the held beat cannot leave yet
    assign w_hold_wait = r_hv && !w_out_free;

    always_comb begin
        n_state = r_state;
        w_push  = 1'b0;
        w_pcode = r_hcode;
        w_plast = 1'b0;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_ACC;
            ST_ACC:   n_state = ST_BT1;
            ST_BT1:   n_state = w_settled ? ST_BT2 : ST_ROT;
            ST_BT2:   n_state = ST_ROT;
            ST_ROT: begin
                if (!w_hit) begin
                    n_state = ST_BTN;
                end else if (!w_hold_wait) begin
                    w_push = r_hv;
                end
            end
            ST_BTN: begin
                if (!r_btnv) begin
                    n_state = ST_FLUSH;
                end else if (!w_hold_wait) begin
                    w_push  = r_hv;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hv) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_push  = 1'b1;
                    w_plast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev   <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ct     <= '0;
            r_stable <= 1'b0;
            r_press  <= '0;
            r_lf     <= 1'b0;
            r_aw     <= 1'b0;
            r_rose   <= 1'b0;
            r_btnv   <= 1'b0;
            r_hv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;

            // result register: load on push, drop once taken
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cnt  <= '0;
                        r_btnv <= 1'b0;
                        r_rose <= 1'b0;
                    end
                end
                ST_DIFF: begin
                    r_diff <= w_y[31:0];
                    r_prev <= r_pos;
                end
                ST_ACC: r_acc <= w_sat;
                ST_BT1: begin
                    r_pend <= r_pressed;
                    r_ct   <= w_ct_eff;
                    if (w_settled) begin
                        r_stable <= r_pressed;
                        r_rose   <= r_stable && !r_pressed;
                        // fresh press: start timing the hold
                        if (!r_stable && r_pressed && !r_aw) begin
                            r_press <= r_now;
                            r_lf    <= 1'b0;
                        end
                    end
                end
                ST_BT2: begin
                    if (w_long_hit) begin
                        r_btnv    <= 1'b1;
                        r_btncode <= EV_LONG;
                        r_lf      <= 1'b1;
                        r_aw      <= 1'b1;
                    end
                    if (r_rose) begin
                        if (w_click_hit) begin
                            r_btnv    <= 1'b1;
                            r_btncode <= EV_CLICK;
                        end
                        r_lf <= 1'b0;
                        r_aw <= 1'b0;
                    end
                end
                ST_ROT: begin
                    if (w_hit && !w_hold_wait) begin
                        r_acc   <= w_y[31:0];
                        r_cnt   <= r_cnt + 1'b1;
                        r_hv    <= 1'b1;
                        r_hcode <= r_acc[31] ? EV_CW : EV_CCW;
                    end
                end
                ST_BTN: begin
                    if (r_btnv && !w_hold_wait) begin
                        r_hv    <= 1'b1;
                        r_hcode <= r_btncode;
                    end
                end
                ST_FLUSH: begin
                    if (w_push) r_hv <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers: latched tick and outgoing beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos     <= i_enc_position;
            r_pressed <= !i_button_level;
            r_now     <= i_now_ms[TIME_WIDTH-1:0];
        end
        if (w_push) begin
            r_ocode <= w_pcode;
            r_olast <= w_plast;
        end
    end

    assign o_valid       = r_ov;
    assign o_event_code  = r_ocode;
    assign o_last_of_run = r_olast;

`ifndef SYNTHESIS
    // detent count per tick never passes the cap
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("detent counter beyond cap");

    // an accepted tick keeps the input side stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepted beat");

    // no beat is left waiting in the held slot once the sequencer is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hv)
        else $error("held beat left behind at idle");

    // a stalled result beat stays valid and keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_event_code) && $stable(o_last_of_run)))
        else $error("stalled result beat changed");
`endif

endmodule

`default_nettype wire
